/* hdl/assert_macros.svh */
// Assertion macros used by the checker file.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while in reset
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* hdl/sfcc_pkg.sv */
// Shared types, constants and functions of the serial frame CRC checker.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package sfcc_pkg;

	// Frame format
	localparam logic [7:0]  SOH_BYTE      = 8'h01;
	localparam logic [7:0]  CR_BYTE       = 8'h0D;
	localparam int          TAIL_BYTES    = 5;
	localparam int          HEX_DIGITS    = 4;
	localparam int          MAX_CRC_SPAN  = 255;

	// Byte counter, saturating
	localparam int          COUNT_W       = 9;
	localparam logic [COUNT_W-1:0] COUNT_MAX     = '1;
	localparam logic [COUNT_W-1:0] MIN_FRAME_LEN = COUNT_W'(9);
	localparam logic [COUNT_W-1:0] CR_INDEX      = COUNT_W'(8);
	localparam logic [COUNT_W-1:0] CRC_FIRST     = COUNT_W'(TAIL_BYTES);
	localparam logic [COUNT_W-1:0] LONG_LIMIT    = COUNT_W'(MAX_CRC_SPAN + TAIL_BYTES);

	// CRC-16, reflected
	localparam logic [15:0] CRC_POLY      = 16'h8408;
	localparam logic [15:0] CRC_START     = 16'hFFFF;

	// Frame queue between front and back
	localparam int          QUEUE_DEPTH   = 2;
	localparam int          QUEUE_AW      = $clog2(QUEUE_DEPTH);

	// Configuration port
	localparam int          PADDR_W       = 1;
	localparam logic [PADDR_W-1:0] REG_BYPASS_ADDR = '0;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_NO_SOH   = 3'd1,
		ST_SHORT    = 3'd2,
		ST_MISMATCH = 3'd3,
		ST_LONG     = 3'd4
	} status_t;

	// One finished frame, handed from front to back
	typedef struct packed {
		logic [HEX_DIGITS-1:0][7:0] digits;   // digits[HEX_DIGITS-1] is most significant
		logic [15:0]                crc;
		logic [COUNT_W-1:0]         count;
		logic                       soh_seen;
		logic                       ninth_is_cr;
	} frame_rec_t;

	// Queue status toward the front
	typedef struct packed {
		logic full;
		logic nonempty;
	} queue_stat_t;

	// One byte through the CRC, LSB first
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
		input logic [7:0] d);
		logic [15:0] c;
		c = crc_in;
		for (int k = 0; k < 8; k++) begin
			if (d[k] ^ c[0])
				c = (c >> 1) ^ CRC_POLY;
			else
				c = c >> 1;
		end
		return c;
	endfunction

	// ASCII hex digit: bit 4 set when the byte is not a hex digit
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		if (c >= 8'h30 && c <= 8'h39)
			r = {1'b0, 4'(c - 8'h30)};
		else if (c >= 8'h41 && c <= 8'h46)
			r = {1'b0, 4'(c - 8'h37)};
		else if (c >= 8'h61 && c <= 8'h66)
			r = {1'b0, 4'(c - 8'h57)};
		else
			r = 5'h10;
		return r;
	endfunction

endpackage

`default_nettype wire

/* hdl/sfcc_front.sv */
// Front end: accepts frame bytes, runs the CRC behind the tail delay line.
// Depends on sfcc_pkg; pushes one record per frame into sfcc_queue.
`timescale 1ns / 1ps
`default_nettype none

module sfcc_front import sfcc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        byte_valid,
	output logic             byte_stall,
	input  wire logic [7:0]  rx_byte,
	input  wire logic        end_of_frame,
	input  wire queue_stat_t qstat,
	output logic             push,
	output frame_rec_t       push_rec
);

	logic [15:0]        crc_q;
	logic [7:0]         tail_q [TAIL_BYTES];
	logic [COUNT_W-1:0] count_q;
	logic               soh_q;
	logic               ninth_q;

	logic               take;
	logic [15:0]        crc_n;
	logic [COUNT_W-1:0] count_n;
	logic               soh_n;
	logic               ninth_n;

	// Hold off only while the queue cannot take a frame record
	assign byte_stall = qstat.full;
	assign take       = byte_valid && !byte_stall;

	// Frame state after this byte
	always_comb begin
		soh_n   = (count_q == '0) ? (rx_byte == SOH_BYTE) : soh_q;
		ninth_n = (count_q == CR_INDEX) ? (rx_byte == CR_BYTE) : ninth_q;
		crc_n   = (count_q >= CRC_FIRST) ? crc16_byte(crc_q, tail_q[0]) : crc_q;
		count_n = (count_q == COUNT_MAX) ? count_q : count_q + 1'b1;
	end

	// Record for the back end; digits are the tail after the shift
	always_comb begin
		for (int k = 0; k < HEX_DIGITS; k++)
			push_rec.digits[HEX_DIGITS-1-k] = tail_q[k+1];
		push_rec.crc         = crc_n;
		push_rec.count       = count_n;
		push_rec.soh_seen    = soh_n;
		push_rec.ninth_is_cr = ninth_n;
	end

	assign push = take && end_of_frame;

	// Frame state registers, cleared after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q   <= CRC_START;
			count_q <= '0;
			soh_q   <= 1'b0;
			ninth_q <= 1'b0;
			for (int k = 0; k < TAIL_BYTES; k++)
				tail_q[k] <= '0;
		end else if (take) begin
			if (end_of_frame) begin
				crc_q   <= CRC_START;
				count_q <= '0;
				soh_q   <= 1'b0;
				ninth_q <= 1'b0;
				for (int k = 0; k < TAIL_BYTES; k++)
					tail_q[k] <= '0;
			end else begin
				crc_q   <= crc_n;
				count_q <= count_n;
				soh_q   <= soh_n;
				ninth_q <= ninth_n;
				for (int k = 0; k < TAIL_BYTES - 1; k++)
					tail_q[k] <= tail_q[k+1];
				tail_q[TAIL_BYTES-1] <= rx_byte;
			end
		end
	end

endmodule

`default_nettype wire

/* hdl/sfcc_queue.sv */
// Short FIFO of finished frame records between front and back end.
// Depends on sfcc_pkg for the record type and depth.
`timescale 1ns / 1ps
`default_nettype none

module sfcc_queue import sfcc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire frame_rec_t  push_rec,
	input  wire logic        pop,
	output frame_rec_t       head_rec,
	output queue_stat_t      qstat
);

	frame_rec_t          entry_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_q;
	logic [QUEUE_AW-1:0] rd_q;
	logic [QUEUE_AW:0]   fill_q;

	assign head_rec       = entry_q[rd_q];
	assign qstat.full     = (fill_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign qstat.nonempty = (fill_q != '0);

	// Entry storage
	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_q] <= push_rec;
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : rd_q + 1'b1;
			unique case ({push, pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

`default_nettype wire

/* hdl/sfcc_back.sv */
// Back end: decodes the hex digits, grades the frame, holds the result.
// Depends on sfcc_pkg; pops records from sfcc_queue.
`timescale 1ns / 1ps
`default_nettype none

module sfcc_back import sfcc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        bypass_en,
	input  wire queue_stat_t qstat,
	input  wire frame_rec_t  head_rec,
	output logic             pop,
	output logic             status_valid,
	input  wire logic        status_stall,
	output logic [2:0]       frame_status,
	output logic [15:0]      computed_crc,
	output logic [15:0]      received_crc
);

	logic        valid_q;
	status_t     status_q;
	logic [15:0] crc_q;
	logic [15:0] rx_q;

	logic        good;
	logic [15:0] rx_val;
	logic [4:0]  nib;
	status_t     status_n;

	// Output register frees when empty or when its transfer completes
	assign pop = qstat.nonempty && (!valid_q || !status_stall);

	// Hex digits, most significant first
	always_comb begin
		good   = 1'b1;
		rx_val = '0;
		nib    = '0;
		for (int k = 0; k < HEX_DIGITS; k++) begin
			nib = hex_decode(head_rec.digits[k]);
			if (nib[4])
				good = 1'b0;
			rx_val[4*k +: 4] = nib[3:0];
		end
		if (!good)
			rx_val = '0;
	end

	// Check order: SOH, length, probe bypass, too long, CRC
	always_comb begin
		priority if (!head_rec.soh_seen)
			status_n = ST_NO_SOH;
		else if (head_rec.count < MIN_FRAME_LEN)
			status_n = ST_SHORT;
		else if (bypass_en && head_rec.ninth_is_cr)
			status_n = ST_OK;
		else if (head_rec.count > LONG_LIMIT)
			status_n = ST_LONG;
		else if (good && rx_val == head_rec.crc)
			status_n = ST_OK;
		else
			status_n = ST_MISMATCH;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (pop)
			valid_q <= 1'b1;
		else if (!status_stall)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			status_q <= status_n;
			crc_q    <= head_rec.crc;
			rx_q     <= rx_val;
		end
	end

	assign status_valid = valid_q;
	assign frame_status = status_q;
	assign computed_crc = crc_q;
	assign received_crc = rx_q;

endmodule

`default_nettype wire

/* hdl/serial_frame_crc_checker_core.sv */
// Serial frame CRC checker, top level: front end, frame queue, back end, config register.
// Depends on sfcc_pkg, sfcc_front, sfcc_queue and sfcc_back.
//
// Usage:
//  Input channel: one frame byte per transfer on rx_byte, with end_of_frame on the
//  last byte. A transfer completes when byte_valid is high and byte_stall is low.
//  Output channel: one result per frame (frame_status, computed_crc, received_crc),
//  moved when status_valid is high and status_stall is low.
//  Throughput: one byte per cycle while byte_stall is low; the CRC byte step is a combinational unrolled update.
//  A frame's result passes through the queue, then the output register; it waits in
//  the queue while a stalled result holds the output register.
//  The front end stalls only when the two-entry frame queue is full, which happens
//  when the receiver stalls the output while further frames finish.
//  Reset clears the frame state, the queue and the output valid; probe bypass
//  resets to enabled. Register 0 (byte address 0, bit 0) is probe_bypass_enable;
//  write it only while no frame is in flight.
`timescale 1ns / 1ps
`default_nettype none

module serial_frame_crc_checker_core import sfcc_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// byte channel
	input  wire logic               byte_valid,
	output logic                    byte_stall,
	input  wire logic [7:0]         rx_byte,
	input  wire logic               end_of_frame,
	// result channel
	output logic                    status_valid,
	input  wire logic               status_stall,
	output logic [2:0]              frame_status,
	output logic [15:0]             computed_crc,
	output logic [15:0]             received_crc,
	// configuration port
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);

	logic        bypass_q;
	logic        push;
	logic        pop;
	frame_rec_t  push_rec;
	frame_rec_t  head_rec;
	queue_stat_t qstat;

	// Configuration register
	assign pready = 1'b1;
	assign prdata = (paddr == REG_BYPASS_ADDR) ? {31'b0, bypass_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			bypass_q <= 1'b1;
		else if (psel && penable && pwrite && pready && paddr == REG_BYPASS_ADDR)
			bypass_q <= pwdata[0];
	end

	sfcc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.rx_byte      (rx_byte),
		.end_of_frame (end_of_frame),
		.qstat        (qstat),
		.push         (push),
		.push_rec     (push_rec)
	);

	sfcc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.pop      (pop),
		.head_rec (head_rec),
		.qstat    (qstat)
	);

	sfcc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.bypass_en    (bypass_q),
		.qstat        (qstat),
		.head_rec     (head_rec),
		.pop          (pop),
		.status_valid (status_valid),
		.status_stall (status_stall),
		.frame_status (frame_status),
		.computed_crc (computed_crc),
		.received_crc (received_crc)
	);

endmodule

`default_nettype wire

/* hdl/sfcc_checker.sv */
// Port-level checker for the serial frame CRC checker, bound to the top level.
// Depends on sfcc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sfcc_checker import sfcc_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        byte_valid,
	input wire logic        byte_stall,
	input wire logic        end_of_frame,
	input wire logic        status_valid,
	input wire logic        status_stall,
	input wire logic [2:0]  frame_status
);

	logic [2:0] pend_q;
	logic       frame_in;
	logic       result_out;

	assign frame_in   = byte_valid && !byte_stall && end_of_frame;
	assign result_out = status_valid && !status_stall;

	// Frames finished but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pend_q <= '0;
		else if (frame_in && !result_out)
			pend_q <= pend_q + 1'b1;
		else if (!frame_in && result_out)
			pend_q <= pend_q - 1'b1;
	end

	`ASSERT_IMPL(a_no_invented_result, status_valid, pend_q != 3'd0)
	`ASSERT_IMPL(a_pending_bounded, 1'b1, pend_q <= 3'd3)
	`ASSERT_IMPL(a_status_code, status_valid, frame_status <= ST_LONG)
	`ASSERT_NEXT(a_result_held, status_valid && status_stall, status_valid && $stable(frame_status))

endmodule

bind serial_frame_crc_checker_core sfcc_checker u_sfcc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.byte_valid   (byte_valid),
	.byte_stall   (byte_stall),
	.end_of_frame (end_of_frame),
	.status_valid (status_valid),
	.status_stall (status_stall),
	.frame_status (frame_status)
);

`default_nettype wire
